[rtl/core/ordered_sequence_store_defines.svh]
// ----------------------------------------------------------------------------
// Ordered sequence store assertion macros
// Shared macros for the concurrent checks of the ordered sequence store.
// ----------------------------------------------------------------------------
`ifndef ORDERED_SEQUENCE_STORE_DEFINES_SVH
`define ORDERED_SEQUENCE_STORE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define OSS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ordered sequence store check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define OSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ordered sequence store check failed");

`endif

[rtl/core/oss_pkg.sv]
// ----------------------------------------------------------------------------
// Ordered sequence store package
// Types and constants shared by the ordered sequence store and its checker.
// ----------------------------------------------------------------------------
package oss_pkg;

  localparam int unsigned OSS_CAPACITY = 256;
  localparam int unsigned ACTION_W     = 3;
  localparam int unsigned POS_W        = 9;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned LENGTH_W     = 9;

  typedef enum logic [ACTION_W-1:0] {
    ACT_APPEND     = 3'd0,
    ACT_POP_BACK   = 3'd1,
    ACT_PUSH_FRONT = 3'd2,
    ACT_POP_FRONT  = 3'd3,
    ACT_INSERT_AT  = 3'd4,
    ACT_ERASE_AT   = 3'd5,
    ACT_CLEAR      = 3'd6
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_RM_RD,
    S_RM_CAP,
    S_FINISH
  } state_e;

  typedef struct packed {
    action_e                    action;
    logic [POS_W-1:0]           position;
    logic signed [VALUE_W-1:0]  value;
  } cmd_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  removed_value;
    status_e                    status;
    logic [LENGTH_W-1:0]        length;
  } result_t;

endpackage

[rtl/core/ordered_sequence_store.sv]
// ----------------------------------------------------------------------------
// Ordered sequence store
// Sequence of signed 32-bit values with push, pop, insert and erase at any
// position, kept in a single-port-write memory.
// ----------------------------------------------------------------------------
// A command transfer happens at a rising edge where start is high and busy is
// low. Each command yields exactly one result on result_o, marked by done_o
// for a single cycle; the receiver cannot stall it.
// Commands that fail their checks, clear, and the unused action code finish
// at once: done_o rises the cycle after the transfer and busy stays low.
// Insert and push move every entry behind the position up by one slot, and
// erase and pop move them down. One shared read-write step of the memory
// moves one entry per cycle, pipelined over the registered read port.
// An insert with entries behind the position runs through the shift state and
// then finish; one with none behind it goes straight to finish. An erase reads
// and captures the removed entry, shifts, then finishes. The result shows in
// the cycle busy falls; a new command may be transferred in that same cycle.
// Reset empties the sequence at once; the memory needs no clearing pass since
// only entries below the length are ever read.
// ----------------------------------------------------------------------------
module ordered_sequence_store #(
  parameter int unsigned CAPACITY = oss_pkg::OSS_CAPACITY
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  oss_pkg::cmd_t   cmd_i,
  output logic            done_o,
  output oss_pkg::result_t result_o
);
  import oss_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;

  logic signed [VALUE_W-1:0] mem [CAPACITY];

  state_e                    state_q, state_d;
  logic [CW-1:0]             count_q, count_d;
  logic [AW-1:0]             idx_q, idx_d;
  logic [AW-1:0]             last_q, last_d;
  logic [AW-1:0]             pos_q, pos_d;
  logic [AW-1:0]             pend_addr_q, pend_addr_d;
  logic                      up_q, up_d;
  logic                      issue_q, issue_d;
  logic                      pend_q, pend_d;
  logic                      is_ins_q, is_ins_d;
  logic                      done_q, done_d;
  logic signed [VALUE_W-1:0] val_q, val_d;
  logic signed [VALUE_W-1:0] removed_q, removed_d;
  result_t                   res_q, res_d;
  logic signed [VALUE_W-1:0] rdata_q;

  logic                      we;
  logic [AW-1:0]             waddr;
  logic signed [VALUE_W-1:0] wdata;
  logic [AW-1:0]             raddr;

  logic [PW-1:0]             pos_w;
  logic [PW-1:0]             cnt_w;
  logic                      full;

  assign cnt_w = PW'(count_q);
  assign full  = (count_q == CW'(CAPACITY));

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
      issue_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
      issue_q <= issue_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    last_q      <= last_d;
    pos_q       <= pos_d;
    pend_addr_q <= pend_addr_d;
    up_q        <= up_d;
    is_ins_q    <= is_ins_d;
    val_q       <= val_d;
    removed_q   <= removed_d;
    res_q       <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    last_d      = last_q;
    pos_d       = pos_q;
    pend_addr_d = pend_addr_q;
    up_d        = up_q;
    issue_d     = issue_q;
    pend_d      = pend_q;
    is_ins_d    = is_ins_q;
    val_d       = val_q;
    removed_d   = removed_q;
    res_d       = res_q;
    done_d      = 1'b0;
    we          = 1'b0;
    waddr       = pend_addr_q;
    wdata       = rdata_q;
    raddr       = idx_q;
    pos_w       = PW'(cmd_i.position);

    case (state_q)
      S_IDLE: begin
        case (cmd_i.action)
          ACT_APPEND: pos_w = cnt_w;
          ACT_PUSH_FRONT, ACT_POP_FRONT: pos_w = '0;
          ACT_POP_BACK: pos_w = cnt_w - PW'(1);
          default: pos_w = PW'(cmd_i.position);
        endcase
        if (start) begin
          val_d = cmd_i.value;
          pos_d = AW'(pos_w);
          res_d = '{removed_value: '0, status: ST_OK, length: LENGTH_W'(count_q)};
          case (cmd_i.action)
            ACT_APPEND, ACT_PUSH_FRONT, ACT_INSERT_AT: begin
              is_ins_d = 1'b1;
              if (pos_w > cnt_w) begin
                res_d.status = ST_RANGE;
                done_d       = 1'b1;
              end else if (full) begin
                res_d.status = ST_FULL;
                done_d       = 1'b1;
              end else if (pos_w == cnt_w) begin
                state_d = S_FINISH;
              end else begin
                idx_d   = AW'(count_q - CW'(1));
                last_d  = AW'(pos_w);
                up_d    = 1'b1;
                issue_d = 1'b1;
                pend_d  = 1'b0;
                state_d = S_SHIFT;
              end
            end
            ACT_POP_BACK, ACT_POP_FRONT, ACT_ERASE_AT: begin
              is_ins_d = 1'b0;
              if (count_q == '0 && cmd_i.action != ACT_ERASE_AT) begin
                res_d.status = ST_EMPTY;
                done_d       = 1'b1;
              end else if (pos_w >= cnt_w) begin
                res_d.status = ST_RANGE;
                done_d       = 1'b1;
              end else begin
                state_d = S_RM_RD;
              end
            end
            ACT_CLEAR: begin
              count_d      = '0;
              res_d.length = '0;
              done_d       = 1'b1;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_RM_RD: begin
        raddr   = pos_q;
        state_d = S_RM_CAP;
      end
      S_RM_CAP: begin
        removed_d = rdata_q;
        pend_d    = 1'b0;
        up_d      = 1'b0;
        idx_d     = pos_q + AW'(1);
        last_d    = AW'(count_q - CW'(1));
        issue_d   = ((CW'(pos_q) + CW'(1)) < count_q);
        state_d   = S_SHIFT;
      end
      S_SHIFT: begin
        we = pend_q;
        if (issue_q) begin
          raddr       = idx_q;
          pend_d      = 1'b1;
          pend_addr_d = up_q ? (idx_q + AW'(1)) : (idx_q - AW'(1));
          if (idx_q == last_q) begin
            issue_d = 1'b0;
          end else begin
            idx_d = up_q ? (idx_q - AW'(1)) : (idx_q + AW'(1));
          end
        end else begin
          pend_d  = 1'b0;
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
        if (is_ins_q) begin
          we      = 1'b1;
          waddr   = pos_q;
          wdata   = val_q;
          count_d = count_q + CW'(1);
          res_d   = '{removed_value: '0, status: ST_OK,
                      length: LENGTH_W'(count_q + CW'(1))};
        end else begin
          count_d = count_q - CW'(1);
          res_d   = '{removed_value: removed_q, status: ST_OK,
                      length: LENGTH_W'(count_q - CW'(1))};
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

[rtl/core/oss_checker.sv]
// ----------------------------------------------------------------------------
// Ordered sequence store checker
// Port-level checks of command and result timing and of result consistency.
// ----------------------------------------------------------------------------
`include "ordered_sequence_store_defines.svh"

module oss_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic             done_o,
  input oss_pkg::result_t result_o
);
  import oss_pkg::*;

  logic xfer;
  logic failed;

  assign xfer   = start && !busy;
  assign failed = (result_o.status == ST_EMPTY) || (result_o.status == ST_RANGE) ||
                  (result_o.status == ST_FULL);

  `OSS_ASSERT_NEXT(a_xfer_answered, clk_i, rst_ni, xfer, busy || done_o)
  `OSS_ASSERT_NEXT(a_no_stray_result, clk_i, rst_ni, !busy && !start, !done_o)
  `OSS_ASSERT_SAME(a_failed_zero, clk_i, rst_ni, done_o && failed, result_o.removed_value == '0)
  `OSS_ASSERT_SAME(a_empty_len, clk_i, rst_ni, done_o && result_o.status == ST_EMPTY,
                   result_o.length == '0)

endmodule

bind ordered_sequence_store oss_checker u_oss_checker (.*);
